FILE: src/directed_cycle_detect_kahn_core_macros.svh
// Assertion macros shared by the checker of directed_cycle_detect_kahn_core.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef DIRECTED_CYCLE_DETECT_KAHN_CORE_MACROS_SVH
`define DIRECTED_CYCLE_DETECT_KAHN_CORE_MACROS_SVH

`define DCDK_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("dcdk check failed");

`define DCDK_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("dcdk check failed");

`define DCDK_ASSERT_NEXT_RST(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("dcdk check failed");

`endif

FILE: src/dcdk_pkg.sv
// Shared types and defaults for the Kahn cycle detector.
// Used by the controller, the datapath and the top level.
package dcdk_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int MAX_EDGES_DEF = 1024;
  localparam logic [8:0] NODE_COUNT_RESET = 9'd256;

  typedef struct packed {
    logic accept;
    logic ld_rd;
    logic ld_wr;
    logic sd_rd;
    logic sd_chk;
    logic pop_rd;
    logic pop_node;
    logic hd_load;
    logic ed_rd;
    logic ed_tgt;
    logic ig_wr;
    logic done;
    logic clear;
  } dcdk_cmd_t;

  typedef struct packed {
    logic op;
    logic ld_ok;
    logic sd_end;
    logic q_empty;
    logic e_null;
    logic t_in;
    logic clr_last;
  } dcdk_sts_t;

endpackage

FILE: src/dcdk_ctrl.sv
// Controller state machine sequencing loads, the Kahn walk and the clear sweep.
// Depends on dcdk_pkg for the command and status structs.
module dcdk_ctrl
  import dcdk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dcdk_sts_t sts,
  output dcdk_cmd_t cmd,
  output logic      busy
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LD_RD    = 4'd1;
  localparam logic [3:0] S_LD_WR    = 4'd2;
  localparam logic [3:0] S_SD_RD    = 4'd3;
  localparam logic [3:0] S_SD_CHK   = 4'd4;
  localparam logic [3:0] S_POP      = 4'd5;
  localparam logic [3:0] S_POP_NODE = 4'd6;
  localparam logic [3:0] S_HD_LOAD  = 4'd7;
  localparam logic [3:0] S_EDGE     = 4'd8;
  localparam logic [3:0] S_ED_TGT   = 4'd9;
  localparam logic [3:0] S_IG_WR    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;
  localparam logic [3:0] S_CLEAR    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_LD_RD;
        end
      end
      S_LD_RD: begin
        if (sts.op) begin
          state_next = S_SD_RD;
        end else begin
          cmd.ld_rd = 1'b1;
          state_next = sts.ld_ok ? S_LD_WR : S_IDLE;
        end
      end
      S_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SD_RD: begin
        if (sts.sd_end) begin
          state_next = S_POP;
        end else begin
          cmd.sd_rd = 1'b1;
          state_next = S_SD_CHK;
        end
      end
      S_SD_CHK: begin
        cmd.sd_chk = 1'b1;
        state_next = S_SD_RD;
      end
      S_POP: begin
        if (sts.q_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP_NODE;
        end
      end
      S_POP_NODE: begin
        cmd.pop_node = 1'b1;
        state_next = S_HD_LOAD;
      end
      S_HD_LOAD: begin
        cmd.hd_load = 1'b1;
        state_next = S_EDGE;
      end
      S_EDGE: begin
        if (sts.e_null) begin
          state_next = S_POP;
        end else begin
          cmd.ed_rd = 1'b1;
          state_next = S_ED_TGT;
        end
      end
      S_ED_TGT: begin
        cmd.ed_tgt = 1'b1;
        state_next = sts.t_in ? S_IG_WR : S_EDGE;
      end
      S_IG_WR: begin
        cmd.ig_wr = 1'b1;
        state_next = S_EDGE;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/dcdk_dp.sv
// Datapath: adjacency, head, indegree and ready-queue memories with counters.
// Depends on dcdk_pkg; driven by dcdk_ctrl through command and status structs.
module dcdk_dp
  import dcdk_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dcdk_cmd_t  cmd,
  output dcdk_sts_t  sts,
  input  logic       op,
  input  logic [7:0] edge_src,
  input  logic [7:0] edge_dst,
  input  logic       cfg_valid,
  input  logic [8:0] cfg_data,
  output logic       result_valid,
  output logic       has_cycle,
  output logic [8:0] ordered_nodes,
  output logic       edges_dropped
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int EI = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int WW = (CW > 9) ? CW : 9;
  localparam logic [EW-1:0] NULL_E = EW'(MAX_EDGES);

  logic [EW-1:0] adj_link_mem [MAX_EDGES];
  logic [NW-1:0] adj_tgt_mem  [MAX_EDGES];
  logic [EW-1:0] head_mem     [MAX_NODES];
  logic [EW-1:0] deg_mem      [MAX_NODES];
  logic [NW-1:0] fifo_mem     [MAX_NODES];

  logic [8:0]    node_count;
  logic          op_q;
  logic [7:0]    src_q;
  logic [7:0]    dst_q;
  logic [EW-1:0] stored;
  logic          drop;
  logic [NW-1:0] clr_idx;
  logic [CW-1:0] idx;
  logic [CW-1:0] qhead;
  logic [CW-1:0] qtail;
  logic [CW-1:0] ordered;
  logic [EW-1:0] cur_e;
  logic [NW-1:0] tnode;
  logic [EW-1:0] head_rd;
  logic [EW-1:0] deg_rd;
  logic [NW-1:0] tgt_rd;
  logic [EW-1:0] link_rd;
  logic [NW-1:0] fifo_rd;

  logic [WW-1:0] ncw;
  logic [CW-1:0] n_eff;
  logic [NW-1:0] head_ra;
  logic [NW-1:0] deg_ra;
  logic          head_we;
  logic [NW-1:0] head_wa;
  logic [EW-1:0] head_wd;
  logic          deg_we;
  logic [NW-1:0] deg_wa;
  logic [EW-1:0] deg_wd;
  logic          push;
  logic [NW-1:0] push_d;

  assign ncw   = WW'(node_count);
  assign n_eff = (ncw > WW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(ncw);

  assign sts.op       = op_q;
  assign sts.ld_ok    = (WW'(src_q) < WW'(n_eff)) && (WW'(dst_q) < WW'(n_eff)) &&
                        (stored != NULL_E);
  assign sts.sd_end   = (idx == n_eff);
  assign sts.q_empty  = (qhead == qtail);
  assign sts.e_null   = (cur_e == NULL_E);
  assign sts.t_in     = (CW'(tgt_rd) < n_eff);
  assign sts.clr_last = (clr_idx == NW'(MAX_NODES - 1));

  always_comb begin
    head_ra = NW'(src_q);
    deg_ra  = NW'(dst_q);
    if (cmd.pop_node) begin
      head_ra = fifo_rd;
    end
    if (cmd.sd_rd) begin
      deg_ra = NW'(idx);
    end else if (cmd.ed_tgt) begin
      deg_ra = tgt_rd;
    end

    head_we = cmd.clear || cmd.ld_wr;
    head_wa = cmd.clear ? clr_idx : NW'(src_q);
    head_wd = cmd.clear ? NULL_E : stored;

    deg_we = cmd.clear || cmd.ld_wr || (cmd.ig_wr && (deg_rd != '0));
    deg_wa = NW'(dst_q);
    deg_wd = deg_rd + EW'(1);
    if (cmd.clear) begin
      deg_wa = clr_idx;
      deg_wd = '0;
    end else if (cmd.ig_wr) begin
      deg_wa = tnode;
      deg_wd = deg_rd - EW'(1);
    end

    push   = (cmd.sd_chk && (deg_rd == '0)) || (cmd.ig_wr && (deg_rd == EW'(1)));
    push_d = cmd.sd_chk ? NW'(idx) : tnode;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_rd <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      adj_tgt_mem[stored[EI-1:0]]  <= NW'(dst_q);
      adj_link_mem[stored[EI-1:0]] <= head_rd;
    end
    if (cmd.ed_rd) begin
      tgt_rd  <= adj_tgt_mem[cur_e[EI-1:0]];
      link_rd <= adj_link_mem[cur_e[EI-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[NW'(qtail)] <= push_d;
    end
    fifo_rd <= fifo_mem[NW'(qhead)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= op;
      src_q <= edge_src;
      dst_q <= edge_dst;
    end
    if (cmd.hd_load) begin
      cur_e <= head_rd;
    end else if (cmd.ed_tgt) begin
      cur_e <= link_rd;
    end
    if (cmd.ed_tgt) begin
      tnode <= tgt_rd;
    end
    if (cmd.done) begin
      has_cycle     <= (ordered != n_eff);
      ordered_nodes <= 9'(ordered);
      edges_dropped <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= NODE_COUNT_RESET;
      stored       <= '0;
      drop         <= 1'b0;
      clr_idx      <= '0;
      idx          <= '0;
      qhead        <= '0;
      qtail        <= '0;
      ordered      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.done;
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      if (cmd.accept) begin
        idx     <= '0;
        qhead   <= '0;
        qtail   <= '0;
        ordered <= '0;
      end
      if (cmd.ld_rd && !sts.ld_ok) begin
        drop <= 1'b1;
      end
      if (cmd.ld_wr) begin
        stored <= stored + EW'(1);
      end
      if (cmd.sd_chk) begin
        idx <= idx + CW'(1);
      end
      if (push) begin
        qtail <= qtail + CW'(1);
      end
      if (cmd.pop_rd) begin
        qhead   <= qhead + CW'(1);
        ordered <= ordered + CW'(1);
      end
      if (cmd.done) begin
        stored <= '0;
        drop   <= 1'b0;
      end
      if (cmd.clear) begin
        clr_idx <= sts.clr_last ? '0 : clr_idx + NW'(1);
      end
    end
  end

endmodule

FILE: src/directed_cycle_detect_kahn_core.sv
// Top level of the Kahn topological-sort cycle detector.
// Depends on dcdk_pkg, dcdk_ctrl and dcdk_dp.
//
// Usage: raise start with op, edge_src and edge_dst; the request is taken
// when start is high and busy is low. op=0 loads one edge in an accept,
// a check and a write state; the write is skipped if the edge is dropped
// as out of range or over capacity. op=1 evaluates: it seeds the ready
// queue, pops nodes and walks edges, each step one registered memory read.
// The result (has_cycle, ordered_nodes, edges_dropped) appears on
// result_valid for one cycle after the walk; it cannot be held off.
// After each evaluate, and after reset, the head and indegree memories are
// swept one node a cycle over all MAX_NODES entries with busy high; the graph
// then starts empty. node_count is written on cfg_valid (cfg_ready is
// always high) and resets to 256.
module directed_cycle_detect_kahn_core
  import dcdk_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       op,
  input  logic [7:0] edge_src,
  input  logic [7:0] edge_dst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data,
  output logic       result_valid,
  output logic       has_cycle,
  output logic [8:0] ordered_nodes,
  output logic       edges_dropped
);

  dcdk_cmd_t cmd;
  dcdk_sts_t sts;

  assign cfg_ready = 1'b1;

  dcdk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dcdk_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .edge_src      (edge_src),
    .edge_dst      (edge_dst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .has_cycle     (has_cycle),
    .ordered_nodes (ordered_nodes),
    .edges_dropped (edges_dropped)
  );

endmodule

FILE: src/dcdk_checker.sv
// Port-level checker for directed_cycle_detect_kahn_core, with its bind.
// Depends on directed_cycle_detect_kahn_core_macros.svh.
`include "directed_cycle_detect_kahn_core_macros.svh"

module dcdk_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic       has_cycle,
  input logic [8:0] ordered_nodes
);

  `DCDK_ASSERT_SAME(a_result_while_busy, result_valid, busy)
  `DCDK_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid)
  `DCDK_ASSERT_NEXT(a_request_busy, start && !busy, busy)
  `DCDK_ASSERT_NEXT_RST(a_reset_sweep, rst, busy)
  `DCDK_ASSERT_SAME(a_count_range, result_valid && has_cycle, ordered_nodes != 9'd256)

endmodule

bind directed_cycle_detect_kahn_core dcdk_checker u_dcdk_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_valid  (result_valid),
  .has_cycle     (has_cycle),
  .ordered_nodes (ordered_nodes)
);
